[design/assert_macros.svh]
// Assertion helpers shared by the RTL files of the frame deframer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_NOW(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("assertion failed in frame deframer");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("assertion failed in frame deframer");

`endif

[design/sldf_pkg.sv]
package sldf_pkg;

    // Frame geometry.
    localparam int MAX_FRAME_BYTES = 256;
    localparam int LEN_CAP         = 252;
    localparam int LEN_UPPER_INT   = (MAX_FRAME_BYTES - 4 > LEN_CAP) ? LEN_CAP
                                                                    : MAX_FRAME_BYTES - 4;
    localparam logic [7:0] LEN_MIN = 8'd4;
    localparam logic [7:0] LEN_MAX = 8'(LEN_UPPER_INT);

    // Byte positions inside a frame.
    localparam logic [7:0] POS_SYNC0  = 8'd0;
    localparam logic [7:0] POS_SYNC1  = 8'd1;
    localparam logic [7:0] POS_SYNC2  = 8'd2;
    localparam logic [7:0] POS_LENGTH = 8'd3;
    localparam logic [7:0] POS_BODY   = 8'd4;

    // Added to the declared length, gives the position of the last frame byte.
    localparam logic [8:0] TAIL_OFFSET = 9'd3;

    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SYNC_FIRST_PRIMARY    = 3'd0,
        CFG_SYNC_SECOND_PRIMARY   = 3'd1,
        CFG_SYNC_THIRD_PRIMARY    = 3'd2,
        CFG_SYNC_FIRST_ALTERNATE  = 3'd3,
        CFG_SYNC_SECOND_ALTERNATE = 3'd4,
        CFG_SYNC_THIRD_ALTERNATE  = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        EV_DISCARD = 3'd0,
        EV_SYNC    = 3'd1,
        EV_LEN_OK  = 3'd2,
        EV_LEN_BAD = 3'd3,
        EV_BODY    = 3'd4,
        EV_CHECK_A = 3'd5,
        EV_GOOD    = 3'd6,
        EV_BAD     = 3'd7
    } event_t;

    typedef struct packed {
        logic [7:0] first_primary;
        logic [7:0] second_primary;
        logic [7:0] third_primary;
        logic [7:0] first_alternate;
        logic [7:0] second_alternate;
        logic [7:0] third_alternate;
    } sync_cfg_t;

    typedef struct packed {
        logic [7:0] echo_byte;
        logic [7:0] frame_position;
        event_t     event_res;
        logic [7:0] declared_length;
        logic [7:0] sum_first;
        logic [7:0] sum_second;
    } result_t;

endpackage

[design/sldf_cfg_regs.sv]
module sldf_cfg_regs
    import sldf_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    output sync_cfg_t              sync_cfg
);

    sync_cfg_t sync_reg;

    // Writes are always taken; indexes past the last register are dropped.
    assign cfg_ready = 1'b1;
    assign sync_cfg  = sync_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg.first_primary    <= 8'd65;
            sync_reg.second_primary   <= 8'd67;
            sync_reg.third_primary    <= 8'd79;
            sync_reg.first_alternate  <= 8'd65;
            sync_reg.second_alternate <= 8'd67;
            sync_reg.third_alternate  <= 8'd79;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                CFG_SYNC_FIRST_PRIMARY:    sync_reg.first_primary    <= cfg_data;
                CFG_SYNC_SECOND_PRIMARY:   sync_reg.second_primary   <= cfg_data;
                CFG_SYNC_THIRD_PRIMARY:    sync_reg.third_primary    <= cfg_data;
                CFG_SYNC_FIRST_ALTERNATE:  sync_reg.first_alternate  <= cfg_data;
                CFG_SYNC_SECOND_ALTERNATE: sync_reg.second_alternate <= cfg_data;
                CFG_SYNC_THIRD_ALTERNATE:  sync_reg.third_alternate  <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

[design/sldf_frame_track.sv]
`include "assert_macros.svh"

module sldf_frame_track
    import sldf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step,
    input  logic [7:0] rx_byte,
    input  sync_cfg_t sync_cfg,
    output result_t   result
);

    logic [7:0] idx_reg, idx_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] sum_a_reg, sum_a_next;
    logic [7:0] sum_b_reg, sum_b_next;
    logic [7:0] check_a_reg, check_a_next;

    logic [7:0] sum_a_add, sum_b_add;
    logic [8:0] pos_plus, frame_end;
    event_t     ev;

    assign sum_a_add = sum_a_reg + rx_byte;
    assign sum_b_add = sum_b_reg + sum_a_add;
    assign pos_plus  = {1'b0, idx_reg} + 9'd1;
    assign frame_end = {1'b0, len_reg} + TAIL_OFFSET;

    always_comb begin
        idx_next     = idx_reg;
        len_next     = len_reg;
        sum_a_next   = sum_a_reg;
        sum_b_next   = sum_b_reg;
        check_a_next = check_a_reg;
        ev           = EV_DISCARD;
        case (idx_reg)
            POS_SYNC0: begin
                if (rx_byte == sync_cfg.first_primary ||
                    rx_byte == sync_cfg.first_alternate) begin
                    sum_a_next = '0;
                    sum_b_next = '0;
                    idx_next   = POS_SYNC1;
                    ev         = EV_SYNC;
                end
            end
            POS_SYNC1: begin
                if (rx_byte == sync_cfg.second_primary ||
                    rx_byte == sync_cfg.second_alternate) begin
                    idx_next = POS_SYNC2;
                    ev       = EV_SYNC;
                end else begin
                    idx_next = POS_SYNC0;
                end
            end
            POS_SYNC2: begin
                if (rx_byte == sync_cfg.third_primary ||
                    rx_byte == sync_cfg.third_alternate) begin
                    sum_a_next = '0;
                    sum_b_next = '0;
                    idx_next   = POS_LENGTH;
                    ev         = EV_SYNC;
                end else begin
                    idx_next = POS_SYNC0;
                end
            end
            POS_LENGTH: begin
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_add;
                len_next   = rx_byte;
                if (rx_byte >= LEN_MIN && rx_byte <= LEN_MAX) begin
                    idx_next = POS_BODY;
                    ev       = EV_LEN_OK;
                end else begin
                    idx_next = POS_SYNC0;
                    ev       = EV_LEN_BAD;
                end
            end
            default: begin
                if (pos_plus < frame_end) begin
                    sum_a_next = sum_a_add;
                    sum_b_next = sum_b_add;
                    idx_next   = pos_plus[7:0];
                    ev         = EV_BODY;
                end else if (pos_plus == frame_end) begin
                    check_a_next = rx_byte;
                    idx_next     = pos_plus[7:0];
                    ev           = EV_CHECK_A;
                end else begin
                    ev = (check_a_reg == sum_a_reg && rx_byte == sum_b_reg) ? EV_GOOD
                                                                          : EV_BAD;
                    idx_next = POS_SYNC0;
                end
            end
        endcase
    end

    // A discarded byte reports nothing but itself.
    always_comb begin
        result.echo_byte = rx_byte;
        result.event_res = ev;
        if (ev == EV_DISCARD) begin
            result.frame_position  = '0;
            result.declared_length = '0;
            result.sum_first       = '0;
            result.sum_second      = '0;
        end else begin
            result.frame_position  = idx_reg;
            result.declared_length = (idx_reg >= POS_LENGTH) ? len_next : 8'd0;
            result.sum_first       = sum_a_next;
            result.sum_second      = sum_b_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            len_reg     <= '0;
            sum_a_reg   <= '0;
            sum_b_reg   <= '0;
            check_a_reg <= '0;
        end else if (step) begin
            idx_reg     <= idx_next;
            len_reg     <= len_next;
            sum_a_reg   <= sum_a_next;
            sum_b_reg   <= sum_b_next;
            check_a_reg <= check_a_next;
        end
    end

    `ASSERT_NEXT(a_frame_end_hunts, aclk, aresetn,
                 step && (ev == EV_GOOD || ev == EV_BAD), idx_reg == POS_SYNC0)
    `ASSERT_NOW(a_index_in_frame, aclk, aresetn,
                idx_reg >= POS_BODY, {1'b0, idx_reg} <= frame_end)
    `ASSERT_NEXT(a_length_bad_hunts, aclk, aresetn,
                 step && ev == EV_LEN_BAD, idx_reg == POS_SYNC0 && len_reg != 8'd0 ||
                 idx_reg == POS_SYNC0)

endmodule

[design/sync_length_frame_deframer.sv]
// Channel | Direction | Handshake          | Payload
// s_      | in        | s_tvalid/s_tready  | s_tdata: rx_byte
// m_      | out       | m_tvalid/m_tready  | m_tdata: byte, position, length, sums
//         |           |                    | m_tuser: event code
// cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Each byte waits in the input register until the result register is free or
// draining, then moves to the result register and is offered to the sink.
// One byte is taken per cycle while the sink keeps taking results; the frame
// tracking state updates as each byte moves to the result register.
// Reset is synchronous and active low; it restores the default sync values.
// A stalled result holds the result register and, once the input register
// is also full, lowers s_tready; nothing is lost or repeated.
`include "assert_macros.svh"

module sync_length_frame_deframer
    import sldf_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] rx_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [39:0]            m_tdata,   // [7:0] echo_byte, [15:8] frame_position,
                                              // [23:16] declared_length,
                                              // [31:24] sum_first, [39:32] sum_second
    output logic [2:0]             m_tuser,   // [2:0] event_res
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data
);

    sync_cfg_t  sync_cfg;
    result_t    result;

    // Input register: holds one accepted request until it can be processed.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Result register: holds one finished result until the sink takes it.
    logic       out_valid_reg;
    result_t    out_res_reg;

    logic       advance;

    // The held byte moves on whenever the result register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    sldf_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sync_cfg  (sync_cfg)
    );

    sldf_frame_track u_track (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .rx_byte  (in_byte_reg),
        .sync_cfg (sync_cfg),
        .result   (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.sum_second, out_res_reg.sum_first,
                       out_res_reg.declared_length, out_res_reg.frame_position,
                       out_res_reg.echo_byte};
    assign m_tuser  = out_res_reg.event_res;

    `ASSERT_NEXT(a_result_loaded, aclk, aresetn, advance, out_valid_reg)
    `ASSERT_NOW(a_no_overrun, aclk, aresetn,
                in_valid_reg && out_valid_reg && !m_tready, !s_tready)
    `ASSERT_NEXT(a_discard_clean, aclk, aresetn,
                 advance && result.event_res == EV_DISCARD,
                 out_res_reg.frame_position == 8'd0 && out_res_reg.sum_first == 8'd0)

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import sldf_pkg::*;

    // Stall limit of the watchdog, in cycles in which nothing is accepted.
    // The longest planned receiver hold-off, HOLD_OFF_CYCLES, is far shorter, so
    // this leaves a wide margin.
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int ITEMS_PER_PHASE = 270;

    // Register indexes that decode to no register; writes there are dropped.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0] cfg_data = 8'h00;

    sync_length_frame_deframer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Bytes waiting to be offered, and results predicted but not yet seen.
    logic [7:0] pend_bytes[$];
    result_t awaited_results[$];
    int queued = 0;
    int mismatches = 0;

    // Traffic shaping, changed by the sequencer only between phases.
    bit sender_bursty = 1'b1;
    rx_mode_t rx_mode = RX_RANDOM;
    bit hold_trigger = 1'b0;

    // Our own copy of the sync registers and of the frame tracking state.
    sync_cfg_t sync_cfg;
    logic [7:0] pos_in_frame;
    logic [7:0] len_seen;
    logic [7:0] fold_a;
    logic [7:0] fold_b;
    logic [7:0] check_a_seen;

    // Set after each rising edge at which the input request was taken.
    logic in_fire = 1'b0;

    function automatic void fold_into_sums(logic [7:0] b);
        fold_a = fold_a + b;
        fold_b = fold_b + fold_a;
    endfunction

    // Works out the result for one received byte and advances the frame state.
    function automatic result_t predict_frame_byte(logic [7:0] b);
        result_t r;
        logic [7:0] pos;
        logic [7:0] len;
        logic [8:0] next_pos;
        event_t ev;
        pos = pos_in_frame;
        len = len_seen;
        next_pos = {1'b0, pos} + 9'd1;
        if (pos == POS_SYNC0) begin
            if (b == sync_cfg.first_primary || b == sync_cfg.first_alternate) begin
                fold_a = 8'h00;
                fold_b = 8'h00;
                pos_in_frame = POS_SYNC1;
                ev = EV_SYNC;
            end else begin
                // A byte that is not a sync byte leaves the hunt where it is.
                ev = EV_DISCARD;
            end
        end else if (pos == POS_SYNC1) begin
            if (b == sync_cfg.second_primary || b == sync_cfg.second_alternate) begin
                pos_in_frame = POS_SYNC2;
                ev = EV_SYNC;
            end else begin
                pos_in_frame = POS_SYNC0;
                ev = EV_DISCARD;
            end
        end else if (pos == POS_SYNC2) begin
            if (b == sync_cfg.third_primary || b == sync_cfg.third_alternate) begin
                fold_a = 8'h00;
                fold_b = 8'h00;
                pos_in_frame = POS_LENGTH;
                ev = EV_SYNC;
            end else begin
                pos_in_frame = POS_SYNC0;
                ev = EV_DISCARD;
            end
        end else if (pos == POS_LENGTH) begin
            fold_into_sums(b);
            len_seen = b;
            len = b;
            if (b >= LEN_MIN && b <= LEN_MAX) begin
                pos_in_frame = POS_BODY;
                ev = EV_LEN_OK;
            end else begin
                pos_in_frame = POS_SYNC0;
                ev = EV_LEN_BAD;
            end
        end else if (next_pos < {1'b0, len} + TAIL_OFFSET) begin
            fold_into_sums(b);
            pos_in_frame = next_pos[7:0];
            ev = EV_BODY;
        end else if (next_pos == {1'b0, len} + TAIL_OFFSET) begin
            check_a_seen = b;
            pos_in_frame = next_pos[7:0];
            ev = EV_CHECK_A;
        end else begin
            ev = (check_a_seen == fold_a && b == fold_b) ? EV_GOOD : EV_BAD;
            pos_in_frame = POS_SYNC0;
        end
        r.echo_byte = b;
        r.event_res = ev;
        if (ev == EV_DISCARD) begin
            r.frame_position = 8'h00;
            r.declared_length = 8'h00;
            r.sum_first = 8'h00;
            r.sum_second = 8'h00;
        end else begin
            r.frame_position = pos;
            r.declared_length = (pos >= POS_LENGTH) ? len : 8'h00;
            r.sum_first = fold_a;
            r.sum_second = fold_b;
        end
        return r;
    endfunction

    task automatic report_field(string field, logic [7:0] want, logic [7:0] got);
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
    endtask

    // Monitor: predicts on every accepted input request, checks every accepted
    // result against the oldest prediction, and tracks register writes.
    result_t got_res;
    result_t want_res;

    always @(posedge aclk) begin
        if (!aresetn) begin
            sync_cfg <= {8'd65, 8'd67, 8'd79, 8'd65, 8'd67, 8'd79};
            pos_in_frame <= POS_SYNC0;
            len_seen <= 8'h00;
            fold_a <= 8'h00;
            fold_b <= 8'h00;
            check_a_seen <= 8'h00;
            in_fire <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SYNC_FIRST_PRIMARY:    sync_cfg.first_primary = cfg_data;
                    CFG_SYNC_SECOND_PRIMARY:   sync_cfg.second_primary = cfg_data;
                    CFG_SYNC_THIRD_PRIMARY:    sync_cfg.third_primary = cfg_data;
                    CFG_SYNC_FIRST_ALTERNATE:  sync_cfg.first_alternate = cfg_data;
                    CFG_SYNC_SECOND_ALTERNATE: sync_cfg.second_alternate = cfg_data;
                    CFG_SYNC_THIRD_ALTERNATE:  sync_cfg.third_alternate = cfg_data;
                    default: begin
                        // Indexes beyond the register list are ignored.
                    end
                endcase
            end
            if (s_tvalid && s_tready) begin
                awaited_results.push_back(predict_frame_byte(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                got_res.echo_byte = m_tdata[7:0];
                got_res.frame_position = m_tdata[15:8];
                got_res.declared_length = m_tdata[23:16];
                got_res.sum_first = m_tdata[31:24];
                got_res.sum_second = m_tdata[39:32];
                got_res.event_res = event_t'(m_tuser);
                if (awaited_results.size() == 0) begin
                    $display("%0t ns: result with nothing expected, actual byte %0d event %0d",
                             $time, got_res.echo_byte, got_res.event_res);
                    mismatches++;
                end else begin
                    want_res = awaited_results.pop_front();
                    if (got_res.echo_byte !== want_res.echo_byte)
                        report_field("echo_byte", want_res.echo_byte, got_res.echo_byte);
                    if (got_res.frame_position !== want_res.frame_position)
                        report_field("frame_position", want_res.frame_position,
                                     got_res.frame_position);
                    if (got_res.event_res !== want_res.event_res)
                        report_field("event_res", 8'(want_res.event_res),
                                     8'(got_res.event_res));
                    if (got_res.declared_length !== want_res.declared_length)
                        report_field("declared_length", want_res.declared_length,
                                     got_res.declared_length);
                    if (got_res.sum_first !== want_res.sum_first)
                        report_field("sum_first", want_res.sum_first, got_res.sum_first);
                    if (got_res.sum_second !== want_res.sum_second)
                        report_field("sum_second", want_res.sum_second, got_res.sum_second);
                end
            end
            in_fire <= s_tvalid && s_tready;
        end
    end

    // Watchdog: any accepted request on any channel restarts the count.
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no request accepted for %0d cycles", $time, idle_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Driver: offers queued bytes, in bursts with gaps when sender_bursty is set.
    // A request that is offered stays put until it has been taken.
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_fire) begin
            // Still waiting for the block to take the current request.
        end else if (gap_left > 0) begin
            s_tvalid <= 1'b0;
            gap_left = gap_left - 1;
        end else if (pend_bytes.size() > 0) begin
            s_tdata <= pend_bytes.pop_front();
            s_tvalid <= 1'b1;
            if (sender_bursty) begin
                if (burst_left > 0) begin
                    burst_left = burst_left - 1;
                end else begin
                    burst_left = $urandom_range(0, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Receiver: its own stall pattern, plus one long hold-off on request so
    // that the block fills up and has to stall its input.
    int rx_tick = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(negedge aclk) begin
        rx_tick = rx_tick + 1;
        if (hold_trigger && !hold_done) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_done = 1'b1;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:  m_tready <= 1'b1;
                RX_RANDOM:  m_tready <= ($urandom_range(0, 99) >= 35);
                default:    m_tready <= ((rx_tick % 9) >= 3);
            endcase
        end
    end

    task automatic queue_byte(logic [7:0] x);
        pend_bytes.push_back(x);
        queued++;
    endtask

    // Either accepted value of one sync position, at random.
    function automatic logic [7:0] pick_sync(int slot);
        bit alt;
        alt = 1'($urandom_range(0, 1));
        case (slot)
            0: return alt ? sync_cfg.first_alternate : sync_cfg.first_primary;
            1: return alt ? sync_cfg.second_alternate : sync_cfg.second_primary;
            default: return alt ? sync_cfg.third_alternate : sync_cfg.third_primary;
        endcase
    endfunction

    // Queues a whole frame of the given length. Bit 0 of damage spoils the
    // first check byte, bit 1 the second.
    task automatic add_frame(int len, int damage);
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] x;
        a = 8'h00;
        b = 8'h00;
        queue_byte(pick_sync(0));
        queue_byte(pick_sync(1));
        queue_byte(pick_sync(2));
        x = len[7:0];
        queue_byte(x);
        a = a + x;
        b = b + a;
        for (int k = 0; k < len - 2; k++) begin
            x = 8'($urandom());
            queue_byte(x);
            a = a + x;
            b = b + a;
        end
        if (damage[0])
            a = a ^ 8'($urandom_range(1, 255));
        if (damage[1])
            b = b ^ 8'($urandom_range(1, 255));
        queue_byte(a);
        queue_byte(b);
    endtask

    // A sync pattern followed by a length outside the accepted range.
    task automatic add_rejected_length(logic [7:0] len);
        queue_byte(pick_sync(0));
        queue_byte(pick_sync(1));
        queue_byte(pick_sync(2));
        queue_byte(len);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic end_writes();
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every queued byte has been taken and every predicted result
    // has arrived, then waits out the two-stage pipeline.
    task automatic drain();
        while (pend_bytes.size() != 0 || s_tvalid) @(posedge aclk);
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Random traffic for one phase: mostly well-formed frames with random content,
    // the rest damaged frames, rejected lengths, broken sync runs and line noise.
    task automatic random_phase(int target);
        int start;
        int pick;
        int len;
        start = queued;
        while (queued - start < target) begin
            pick = $urandom_range(0, 99);
            len = $urandom_range(0, 99);
            if (len < 2)
                len = LEN_MAX;
            else if (len < 10)
                len = $urandom_range(25, 120);
            else
                len = $urandom_range(LEN_MIN, 24);
            if (pick < 60) begin
                add_frame(len, 0);
            end else if (pick < 72) begin
                add_frame(len, $urandom_range(1, 3));
            end else if (pick < 80) begin
                if ($urandom_range(0, 1))
                    add_rejected_length(8'($urandom_range(0, LEN_MIN - 1)));
                else
                    add_rejected_length(8'($urandom_range(LEN_MAX + 1, 255)));
            end else if (pick < 88) begin
                queue_byte(pick_sync(0));
                if ($urandom_range(0, 1))
                    queue_byte(pick_sync(1));
                queue_byte(8'($urandom()));
            end else begin
                repeat ($urandom_range(1, 4)) queue_byte(8'($urandom()));
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part with the reset sync values: shortest frame, lengths
        // just outside either bound, the extreme byte values as noise, sync
        // broken at its second and third byte, and a repeated first sync byte
        // that must not restart the hunt.
        sender_bursty = 1'b1;
        rx_mode = RX_RANDOM;
        add_frame(LEN_MIN, 0);
        add_rejected_length(LEN_MIN - 8'd1);
        add_rejected_length(LEN_MAX + 8'd1);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(sync_cfg.first_primary);
        queue_byte(8'h00);
        queue_byte(sync_cfg.first_primary);
        queue_byte(sync_cfg.second_primary);
        queue_byte(8'hFF);
        queue_byte(sync_cfg.first_primary);
        queue_byte(sync_cfg.first_primary);
        queue_byte(sync_cfg.second_primary);
        drain();

        // Random sync values everywhere, bursty sender, random stalls.
        write_reg(CFG_SYNC_FIRST_PRIMARY, 8'($urandom()));
        write_reg(CFG_SYNC_SECOND_PRIMARY, 8'($urandom()));
        write_reg(CFG_SYNC_THIRD_PRIMARY, 8'($urandom()));
        write_reg(CFG_SYNC_FIRST_ALTERNATE, 8'($urandom()));
        write_reg(CFG_SYNC_SECOND_ALTERNATE, 8'($urandom()));
        write_reg(CFG_SYNC_THIRD_ALTERNATE, 8'($urandom()));
        end_writes();
        random_phase(ITEMS_PER_PHASE);
        drain();

        // Extreme values, a steady sender and one long receiver hold-off.
        write_reg(CFG_SYNC_FIRST_PRIMARY, 8'h00);
        write_reg(CFG_SYNC_SECOND_PRIMARY, 8'h00);
        write_reg(CFG_SYNC_THIRD_PRIMARY, 8'h00);
        write_reg(CFG_SYNC_FIRST_ALTERNATE, 8'hFF);
        write_reg(CFG_SYNC_SECOND_ALTERNATE, 8'hFF);
        write_reg(CFG_SYNC_THIRD_ALTERNATE, 8'hFF);
        end_writes();
        sender_bursty = 1'b0;
        hold_trigger = 1'b1;
        random_phase(ITEMS_PER_PHASE);
        drain();

        // The opposite extremes; the spare indexes must change nothing.
        write_reg(CFG_SYNC_FIRST_PRIMARY, 8'hFF);
        write_reg(CFG_SYNC_SECOND_PRIMARY, 8'hFF);
        write_reg(CFG_SYNC_THIRD_PRIMARY, 8'hFF);
        write_reg(CFG_SYNC_FIRST_ALTERNATE, 8'h00);
        write_reg(CFG_SYNC_SECOND_ALTERNATE, 8'h00);
        write_reg(CFG_SYNC_THIRD_ALTERNATE, 8'h00);
        write_reg(CFG_SPARE_LO, 8'($urandom()));
        write_reg(CFG_SPARE_HI, 8'($urandom()));
        end_writes();
        sender_bursty = 1'b1;
        rx_mode = RX_PATTERN;
        random_phase(ITEMS_PER_PHASE);
        drain();

        // Fresh random values and a stretch with no idling on either side.
        write_reg(CFG_SYNC_THIRD_ALTERNATE, 8'($urandom()));
        write_reg(CFG_SYNC_SECOND_ALTERNATE, 8'($urandom()));
        write_reg(CFG_SYNC_FIRST_ALTERNATE, 8'($urandom()));
        write_reg(CFG_SYNC_THIRD_PRIMARY, 8'($urandom()));
        write_reg(CFG_SYNC_SECOND_PRIMARY, 8'($urandom()));
        write_reg(CFG_SYNC_FIRST_PRIMARY, 8'($urandom()));
        end_writes();
        sender_bursty = 1'b0;
        rx_mode = RX_ALWAYS;
        random_phase(ITEMS_PER_PHASE);
        drain();

        repeat (8) @(posedge aclk);
        if (awaited_results.size() != 0) begin
            $display("%0t ns: %0d expected results never arrived", $time,
                     awaited_results.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
